>>> hw/rtl/fifo_ready_queue_scheduler_assert.svh
// Assertion macros for the ready queue scheduler checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FIFO_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define FIFO_READY_QUEUE_SCHEDULER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define FRQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frqs: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define FRQS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frqs: next-cycle check failed");

`endif

>>> hw/rtl/frqs_pkg.sv
// Package of the ready queue scheduler: field widths, codes and the
// control word types shared by the sequencer and the datapath. No dependencies.
`timescale 1ns / 1ps

package frqs_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned ThreadIdBitsDef = 8;

  // Fixed widths of the request and result fields.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned IdPortW   = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountPortW = 5;

  // Request action codes.
  typedef enum logic [ActionW-1:0] {
    ACT_ENQUEUE   = 2'd0,
    ACT_YIELD     = 2'd1,
    ACT_TERMINATE = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_WRITE_TAIL,
    OP_SET_FULL,
    OP_READ_HEAD,
    OP_TAKE_HEAD,
    OP_SET_EMPTY,
    OP_CLEAR_IDX,
    OP_READ_IDX,
    OP_STEP_READ,
    OP_SET_NOT_FOUND,
    OP_READ_NEXT,
    OP_WRITE_SHIFT,
    OP_DROP_ENTRY,
    OP_LOAD_OUT
  } uop_e;

  // Jump conditions tested by a control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_ACT_ENQ,
    C_IS_POP,
    C_ACT_TERM,
    C_FULL,
    C_EMPTY,
    C_MATCH,
    C_LAST,
    C_OUT_FULL
  } cond_e;

  localparam int unsigned PcW = 5;
  typedef logic [PcW-1:0] pc_t;

  // One step of the control program.
  typedef struct packed {
    logic  in_ready;
    uop_e  op;
    cond_e cond;
    logic  negate;
    pc_t   target;
  } uword_t;

  // Status flags from the datapath, tested by the sequencer.
  typedef struct packed {
    logic no_req;
    logic act_enq;
    logic is_pop;
    logic act_term;
    logic full;
    logic empty;
    logic match;
    logic last;
    logic out_full;
  } flags_t;

endpackage

>>> hw/rtl/frqs_if.sv
// Request and result channel interfaces of the ready queue scheduler.
// Depends on frqs_pkg for the field widths.
`timescale 1ns / 1ps

interface frqs_req_if;
  logic                            valid;
  logic                            ready;
  logic [frqs_pkg::ActionW-1:0]    action;
  logic [frqs_pkg::IdPortW-1:0]    thread_id;

  modport source (output valid, action, thread_id, input ready);
  modport sink (input valid, action, thread_id, output ready);
endinterface

interface frqs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              dispatch_valid;
  logic [frqs_pkg::IdPortW-1:0]      dispatched_id;
  logic [frqs_pkg::StatusW-1:0]      status;
  logic [frqs_pkg::CountPortW-1:0]   queue_count;

  modport source (output valid, dispatch_valid, dispatched_id, status, queue_count,
                  input ready);
  modport sink (input valid, dispatch_valid, dispatched_id, status, queue_count,
                output ready);
endinterface

>>> hw/rtl/frqs_useq.sv
// Microcode sequencer: step counter, control program ROM and jump logic.
// Depends on frqs_pkg for the control word and flag types.
`timescale 1ns / 1ps

module frqs_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  frqs_pkg::flags_t flags_i,
  output frqs_pkg::uword_t ctl_o
);

  // Program addresses.
  localparam frqs_pkg::pc_t PcWait      = 5'd0;
  localparam frqs_pkg::pc_t PcDecEnq    = 5'd1;
  localparam frqs_pkg::pc_t PcDecPop    = 5'd2;
  localparam frqs_pkg::pc_t PcDecTerm   = 5'd3;
  localparam frqs_pkg::pc_t PcNop       = 5'd4;
  localparam frqs_pkg::pc_t PcEnq       = 5'd5;
  localparam frqs_pkg::pc_t PcEnqWrite  = 5'd6;
  localparam frqs_pkg::pc_t PcEnqFull   = 5'd7;
  localparam frqs_pkg::pc_t PcPop       = 5'd8;
  localparam frqs_pkg::pc_t PcPopTake   = 5'd9;
  localparam frqs_pkg::pc_t PcPopEmpty  = 5'd10;
  localparam frqs_pkg::pc_t PcTerm      = 5'd11;
  localparam frqs_pkg::pc_t PcTermRead  = 5'd12;
  localparam frqs_pkg::pc_t PcTermCmp   = 5'd13;
  localparam frqs_pkg::pc_t PcTermNext  = 5'd14;
  localparam frqs_pkg::pc_t PcTermMiss  = 5'd15;
  localparam frqs_pkg::pc_t PcShift     = 5'd16;
  localparam frqs_pkg::pc_t PcShiftWr   = 5'd17;
  localparam frqs_pkg::pc_t PcShiftDone = 5'd18;
  localparam frqs_pkg::pc_t PcOutWait   = 5'd19;
  localparam frqs_pkg::pc_t PcOutLoad   = 5'd20;

  function automatic frqs_pkg::uword_t mk(logic rdy, frqs_pkg::uop_e op,
                                          frqs_pkg::cond_e cond, logic neg,
                                          frqs_pkg::pc_t tgt);
    frqs_pkg::uword_t w;
    w.in_ready = rdy;
    w.op       = op;
    w.cond     = cond;
    w.negate   = neg;
    w.target   = tgt;
    return w;
  endfunction

  // The control program. Each step runs its operation and jumps to its
  // target when the condition (optionally inverted) holds, else goes on.
  function automatic frqs_pkg::uword_t ucode(frqs_pkg::pc_t pc);
    frqs_pkg::uword_t w;
    w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_ALWAYS, 1'b0, PcWait);
    unique case (pc)
      PcWait:      w = mk(1'b1, frqs_pkg::OP_LATCH, frqs_pkg::C_NO_REQ, 1'b0, PcWait);
      PcDecEnq:    w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_ACT_ENQ, 1'b0, PcEnq);
      PcDecPop:    w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_IS_POP, 1'b0, PcPop);
      PcDecTerm:   w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_ACT_TERM, 1'b0, PcTerm);
      PcNop:       w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_ALWAYS, 1'b0, PcOutWait);
      PcEnq:       w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_FULL, 1'b0, PcEnqFull);
      PcEnqWrite:  w = mk(1'b0, frqs_pkg::OP_WRITE_TAIL, frqs_pkg::C_ALWAYS, 1'b0,
                          PcOutWait);
      PcEnqFull:   w = mk(1'b0, frqs_pkg::OP_SET_FULL, frqs_pkg::C_ALWAYS, 1'b0, PcOutWait);
      PcPop:       w = mk(1'b0, frqs_pkg::OP_READ_HEAD, frqs_pkg::C_EMPTY, 1'b0, PcPopEmpty);
      PcPopTake:   w = mk(1'b0, frqs_pkg::OP_TAKE_HEAD, frqs_pkg::C_ALWAYS, 1'b0, PcOutWait);
      PcPopEmpty:  w = mk(1'b0, frqs_pkg::OP_SET_EMPTY, frqs_pkg::C_ALWAYS, 1'b0, PcOutWait);
      PcTerm:      w = mk(1'b0, frqs_pkg::OP_CLEAR_IDX, frqs_pkg::C_EMPTY, 1'b0, PcTermMiss);
      PcTermRead:  w = mk(1'b0, frqs_pkg::OP_READ_IDX, frqs_pkg::C_NEVER, 1'b0, PcWait);
      PcTermCmp:   w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_MATCH, 1'b0, PcShift);
      PcTermNext:  w = mk(1'b0, frqs_pkg::OP_STEP_READ, frqs_pkg::C_LAST, 1'b1, PcTermCmp);
      PcTermMiss:  w = mk(1'b0, frqs_pkg::OP_SET_NOT_FOUND, frqs_pkg::C_ALWAYS, 1'b0,
                          PcOutWait);
      PcShift:     w = mk(1'b0, frqs_pkg::OP_READ_NEXT, frqs_pkg::C_LAST, 1'b0, PcShiftDone);
      PcShiftWr:   w = mk(1'b0, frqs_pkg::OP_WRITE_SHIFT, frqs_pkg::C_ALWAYS, 1'b0, PcShift);
      PcShiftDone: w = mk(1'b0, frqs_pkg::OP_DROP_ENTRY, frqs_pkg::C_ALWAYS, 1'b0,
                          PcOutWait);
      PcOutWait:   w = mk(1'b0, frqs_pkg::OP_NONE, frqs_pkg::C_OUT_FULL, 1'b0, PcOutWait);
      PcOutLoad:   w = mk(1'b0, frqs_pkg::OP_LOAD_OUT, frqs_pkg::C_ALWAYS, 1'b0, PcWait);
      default: ;
    endcase
    return w;
  endfunction

  frqs_pkg::pc_t    pc_q, pc_d;
  frqs_pkg::uword_t word;
  logic             cond_hit;

  assign word  = ucode(pc_q);
  assign ctl_o = word;

  // Condition select.
  always_comb begin
    unique case (word.cond)
      frqs_pkg::C_NEVER:    cond_hit = 1'b0;
      frqs_pkg::C_ALWAYS:   cond_hit = 1'b1;
      frqs_pkg::C_NO_REQ:   cond_hit = flags_i.no_req;
      frqs_pkg::C_ACT_ENQ:  cond_hit = flags_i.act_enq;
      frqs_pkg::C_IS_POP:   cond_hit = flags_i.is_pop;
      frqs_pkg::C_ACT_TERM: cond_hit = flags_i.act_term;
      frqs_pkg::C_FULL:     cond_hit = flags_i.full;
      frqs_pkg::C_EMPTY:    cond_hit = flags_i.empty;
      frqs_pkg::C_MATCH:    cond_hit = flags_i.match;
      frqs_pkg::C_LAST:     cond_hit = flags_i.last;
      frqs_pkg::C_OUT_FULL: cond_hit = flags_i.out_full;
      default:              cond_hit = 1'b0;
    endcase
  end

  // Next step: jump target or the following step.
  always_comb begin
    if (cond_hit ^ word.negate) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> hw/rtl/frqs_dpath.sv
// Datapath of the ready queue scheduler: id ring memory, queue pointers,
// running thread, scan index and result register. Depends on frqs_pkg.
`timescale 1ns / 1ps

module frqs_dpath #(
  parameter int unsigned QueueDepth   = frqs_pkg::QueueDepthDef,
  parameter int unsigned ThreadIdBits = frqs_pkg::ThreadIdBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  frqs_pkg::uop_e                      op_i,
  input  logic                                req_valid_i,
  input  logic [frqs_pkg::ActionW-1:0]        req_action_i,
  input  logic [frqs_pkg::IdPortW-1:0]        req_thread_id_i,
  input  logic                                rsp_ready_i,
  output frqs_pkg::flags_t                    flags_o,
  output logic                                rsp_valid_o,
  output logic                                rsp_dispatch_valid_o,
  output logic [frqs_pkg::IdPortW-1:0]        rsp_dispatched_id_o,
  output logic [frqs_pkg::StatusW-1:0]        rsp_status_o,
  output logic [frqs_pkg::CountPortW-1:0]     rsp_queue_count_o
);

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdExtW =
      (ThreadIdBits > frqs_pkg::IdPortW) ? ThreadIdBits : frqs_pkg::IdPortW;
  localparam int unsigned CntExtW =
      (CntW > frqs_pkg::CountPortW) ? CntW : frqs_pkg::CountPortW;
  localparam logic [IdxW:0]   DepthW = (IdxW + 1)'(QueueDepth);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);

  // Ring index of the entry at the given offset from a base slot.
  function automatic logic [IdxW-1:0] ring_pos(logic [IdxW-1:0] base, logic [IdxW:0] off);
    logic [IdxW:0] s;
    s = {1'b0, base} + off;
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[IdxW-1:0];
  endfunction

  // Id ring storage, one write and one registered read per cycle.
  logic [ThreadIdBits-1:0] mem_q [QueueDepth];

  frqs_pkg::action_e        act_q;
  logic [ThreadIdBits-1:0]  id_q, rd_q, run_id_q;
  logic                     run_v_q;
  logic [CntW-1:0]          count_q;
  logic [IdxW-1:0]          front_q, idx_q;
  logic                     disp_q;
  frqs_pkg::status_e        status_q;

  logic                             ov_q, o_disp_q;
  logic [frqs_pkg::IdPortW-1:0]     o_id_q;
  frqs_pkg::status_e                o_status_q;
  logic [frqs_pkg::CountPortW-1:0]  o_count_q;

  logic [IdExtW-1:0]        req_id_ext, run_id_ext;
  logic [CntExtW-1:0]       count_ext;
  logic [IdxW:0]            count_w, idx_next_w;
  logic                     mem_we, mem_re;
  logic [IdxW-1:0]          waddr, raddr;
  logic [ThreadIdBits-1:0]  wdata;
  logic                     load_out;

  assign req_id_ext = IdExtW'(req_thread_id_i);
  assign run_id_ext = IdExtW'(run_id_q);
  assign count_ext  = CntExtW'(count_q);
  assign count_w    = (IdxW + 1)'(count_q);
  assign idx_next_w = {1'b0, idx_q} + 1'b1;
  assign load_out   = (op_i == frqs_pkg::OP_LOAD_OUT);

  // Flags for the sequencer.
  always_comb begin
    flags_o.no_req   = !req_valid_i;
    flags_o.act_enq  = (act_q == frqs_pkg::ACT_ENQUEUE);
    flags_o.is_pop   = (act_q == frqs_pkg::ACT_YIELD) ||
                       ((act_q == frqs_pkg::ACT_TERMINATE) && run_v_q && (run_id_q == id_q));
    flags_o.act_term = (act_q == frqs_pkg::ACT_TERMINATE);
    flags_o.full     = (count_q == DepthC);
    flags_o.empty    = (count_q == '0);
    flags_o.match    = (rd_q == id_q);
    flags_o.last     = (idx_next_w == count_w);
    flags_o.out_full = ov_q && !rsp_ready_i;
  end

  // Memory port addresses and enables.
  always_comb begin
    mem_we = (op_i == frqs_pkg::OP_WRITE_TAIL) || (op_i == frqs_pkg::OP_WRITE_SHIFT);
    mem_re = (op_i == frqs_pkg::OP_READ_HEAD) || (op_i == frqs_pkg::OP_READ_IDX) ||
             (op_i == frqs_pkg::OP_STEP_READ) || (op_i == frqs_pkg::OP_READ_NEXT);
    if (op_i == frqs_pkg::OP_WRITE_TAIL) begin
      waddr = ring_pos(front_q, count_w);
      wdata = id_q;
    end else begin
      waddr = ring_pos(front_q, {1'b0, idx_q});
      wdata = rd_q;
    end
    if (op_i == frqs_pkg::OP_READ_HEAD) begin
      raddr = front_q;
    end else if (op_i == frqs_pkg::OP_READ_IDX) begin
      raddr = ring_pos(front_q, {1'b0, idx_q});
    end else begin
      raddr = ring_pos(front_q, idx_next_w);
    end
  end

  // Ring memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Queue pointers, running thread and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      front_q  <= '0;
      run_id_q <= '0;
      run_v_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      unique case (op_i)
        frqs_pkg::OP_WRITE_TAIL: count_q <= count_q + 1'b1;
        frqs_pkg::OP_TAKE_HEAD: begin
          run_id_q <= rd_q;
          run_v_q  <= 1'b1;
          front_q  <= ring_pos(front_q, (IdxW + 1)'(1));
          count_q  <= count_q - 1'b1;
        end
        frqs_pkg::OP_DROP_ENTRY: count_q <= count_q - 1'b1;
        default: ;
      endcase
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (rsp_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Request latch, scan index, per-item flags and result fields.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      frqs_pkg::OP_LATCH: begin
        if (req_valid_i) begin
          act_q    <= frqs_pkg::action_e'(req_action_i);
          id_q     <= req_id_ext[ThreadIdBits-1:0];
          disp_q   <= 1'b0;
          status_q <= frqs_pkg::ST_OK;
        end
      end
      frqs_pkg::OP_SET_FULL:      status_q <= frqs_pkg::ST_FULL;
      frqs_pkg::OP_SET_EMPTY:     status_q <= frqs_pkg::ST_EMPTY;
      frqs_pkg::OP_SET_NOT_FOUND: status_q <= frqs_pkg::ST_NOT_FOUND;
      frqs_pkg::OP_TAKE_HEAD:     disp_q   <= 1'b1;
      frqs_pkg::OP_CLEAR_IDX:     idx_q    <= '0;
      frqs_pkg::OP_STEP_READ,
      frqs_pkg::OP_WRITE_SHIFT:   idx_q    <= idx_q + 1'b1;
      frqs_pkg::OP_LOAD_OUT: begin
        o_disp_q   <= disp_q;
        o_id_q     <= run_id_ext[frqs_pkg::IdPortW-1:0];
        o_status_q <= status_q;
        o_count_q  <= count_ext[frqs_pkg::CountPortW-1:0];
      end
      default: ;
    endcase
  end

  assign rsp_valid_o          = ov_q;
  assign rsp_dispatch_valid_o = o_disp_q;
  assign rsp_dispatched_id_o  = o_id_q;
  assign rsp_status_o         = o_status_q;
  assign rsp_queue_count_o    = o_count_q;

endmodule

>>> hw/rtl/fifo_ready_queue_scheduler.sv
// Top level of the ready queue scheduler: microcode sequencer plus datapath.
// Depends on frqs_pkg, frqs_if, frqs_useq and frqs_dpath.
//
//   channel  dir  modport  payload
//   req_i    in   sink     action, thread_id
//   rsp_o    out  source   dispatch_valid, dispatched_id, status, queue_count
//
// One request at a time. Each request is latched, decoded and run through its steps,
// then waits for the result register to be free and loads its result. A terminate of
// a queued thread scans from the head and closes up the entries behind the match.
// Each waiting entry costs two steps of the control program in that scan and shift.
// Reset is asynchronous; no clearing pass. The next request is taken the cycle after
// a result loads; a stalled result only holds the following request at its last step.
`timescale 1ns / 1ps

module fifo_ready_queue_scheduler #(
  parameter int unsigned QueueDepth   = frqs_pkg::QueueDepthDef,
  parameter int unsigned ThreadIdBits = frqs_pkg::ThreadIdBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frqs_req_if.sink   req_i,
  frqs_rsp_if.source rsp_o
);

  frqs_pkg::uword_t ctl;
  frqs_pkg::flags_t flags;

  // Control program.
  frqs_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  // Queue storage and result register.
  frqs_dpath #(
    .QueueDepth   (QueueDepth),
    .ThreadIdBits (ThreadIdBits)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .op_i                 (ctl.op),
    .req_valid_i          (req_i.valid),
    .req_action_i         (req_i.action),
    .req_thread_id_i      (req_i.thread_id),
    .rsp_ready_i          (rsp_o.ready),
    .flags_o              (flags),
    .rsp_valid_o          (rsp_o.valid),
    .rsp_dispatch_valid_o (rsp_o.dispatch_valid),
    .rsp_dispatched_id_o  (rsp_o.dispatched_id),
    .rsp_status_o         (rsp_o.status),
    .rsp_queue_count_o    (rsp_o.queue_count)
  );

  assign req_i.ready = ctl.in_ready;

endmodule

>>> hw/rtl/frqs_checker.sv
// Port-level checker of the ready queue scheduler and its bind to the top.
// Depends on frqs_pkg and fifo_ready_queue_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "fifo_ready_queue_scheduler_assert.svh"

module frqs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              out_dispatch_i,
  input logic [frqs_pkg::IdPortW-1:0]      out_id_i,
  input logic [frqs_pkg::StatusW-1:0]      out_status_i,
  input logic [frqs_pkg::CountPortW-1:0]   out_count_i
);

  // The block works on one request at a time.
  `FRQS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // A dispatch only comes with a good status.
  `FRQS_ASSERT_IMP(a_dispatch_ok, out_valid_i && out_dispatch_i,
                   out_status_i == frqs_pkg::ST_OK)

  // An empty pop leaves nothing queued and dispatches nothing.
  `FRQS_ASSERT_IMP(a_empty_pop, out_valid_i && (out_status_i == frqs_pkg::ST_EMPTY),
                   (out_count_i == '0) && !out_dispatch_i)

  // A stalled result holds.
  `FRQS_ASSERT_NXT(a_rsp_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_id_i) && $stable(out_status_i) &&
                   $stable(out_count_i) && $stable(out_dispatch_i))

endmodule

bind fifo_ready_queue_scheduler frqs_checker u_frqs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .out_dispatch_i (rsp_o.dispatch_valid),
  .out_id_i       (rsp_o.dispatched_id),
  .out_status_i   (rsp_o.status),
  .out_count_i    (rsp_o.queue_count)
);

>>> tb/frqs_dispatch_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ready queue scheduler: watches the request and result channels,
// predicts every result from its own model of the queue and compares them in order.
// Depends on frqs_pkg and the channel interfaces in frqs_if.

module frqs_dispatch_checker #(
  parameter int unsigned QueueDepth = frqs_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frqs_req_if         req_i,
  frqs_rsp_if         rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned checked_cnt_o,
  output int unsigned dispatch_cnt_o,
  output int unsigned empty_cnt_o,
  output int unsigned full_cnt_o,
  output int unsigned miss_cnt_o
);
  import frqs_pkg::*;

  // One result as the block reports it.
  typedef struct packed {
    logic                  dispatched;
    logic [IdPortW-1:0]    run_id;
    status_e               status;
    logic [CountPortW-1:0] depth;
  } sched_result_t;

  // Shadow copy of the scheduler state.
  logic [IdPortW-1:0] ready_ids[$];
  logic [IdPortW-1:0] run_id = '0;
  logic               run_valid = 1'b0;

  // Results predicted for accepted requests, oldest first.
  sched_result_t awaited_results[$];

  initial begin
    fail_cnt_o     = 0;
    pending_cnt_o  = 0;
    checked_cnt_o  = 0;
    dispatch_cnt_o = 0;
    empty_cnt_o    = 0;
    full_cnt_o     = 0;
    miss_cnt_o     = 0;
  end

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic sched_result_t schedule_step(input action_e act,
                                                   input logic [IdPortW-1:0] tid);
    sched_result_t res;
    int            hit;
    res.dispatched = 1'b0;
    res.status     = ST_OK;
    hit            = -1;
    if (act == ACT_ENQUEUE) begin
      if (ready_ids.size() >= QueueDepth) begin
        res.status = ST_FULL;
      end else begin
        ready_ids.push_back(tid);
      end
    end else if (act == ACT_YIELD ||
                 (act == ACT_TERMINATE && run_valid && run_id == tid)) begin
      // Killing the running thread is handled as a yield.
      if (ready_ids.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        run_id         = ready_ids.pop_front();
        run_valid      = 1'b1;
        res.dispatched = 1'b1;
      end
    end else if (act == ACT_TERMINATE) begin
      // Only the match nearest the head goes; the rest close up behind it.
      for (int i = 0; i < ready_ids.size(); i++) begin
        if (hit < 0 && ready_ids[i] == tid) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        ready_ids.delete(hit);
      end
    end
    res.run_id = run_id;
    res.depth  = CountPortW'(ready_ids.size());
    return res;
  endfunction

  // Compare results first, since a result taken at the same edge as a new
  // request always belongs to an earlier one.
  always @(posedge clk_i) begin : scoreboard
    sched_result_t want;
    sched_result_t got;
    if (!rst_ni) begin
      ready_ids.delete();
      awaited_results.delete();
      run_id    = '0;
      run_valid = 1'b0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.dispatched = rsp_i.dispatch_valid;
        got.run_id     = rsp_i.dispatched_id;
        got.status     = status_e'(rsp_i.status);
        got.depth      = rsp_i.queue_count;
        checked_cnt_o++;
        if (awaited_results.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: result with no request outstanding: disp=%0b id=%0h st=%0d cnt=%0d",
                     $realtime, got.dispatched, got.run_id, got.status, got.depth);
        end else begin
          want = awaited_results.pop_front();
          if (want !== got) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("%0t: result mismatch: expected disp=%0b id=%0h st=%0d cnt=%0d, got disp=%0b id=%0h st=%0d cnt=%0d",
                       $realtime, want.dispatched, want.run_id, want.status, want.depth,
                       got.dispatched, got.run_id, got.status, got.depth);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = schedule_step(action_e'(req_i.action), req_i.thread_id);
        awaited_results.push_back(want);
        if (want.dispatched) dispatch_cnt_o++;
        if (want.status == ST_EMPTY) empty_cnt_o++;
        if (want.status == ST_FULL) full_cnt_o++;
        if (want.status == ST_NOT_FOUND) miss_cnt_o++;
      end
    end
    pending_cnt_o = awaited_results.size();
  end

endmodule

>>> tb/tb_fifo_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// Testbench top for the ready queue scheduler: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on frqs_pkg, frqs_if and the checker.

module tb_fifo_ready_queue_scheduler;
  import frqs_pkg::*;

  localparam int unsigned ItemsPerPhase = 275;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 4 * QueueDepthDef + 32;
  localparam int unsigned CycleLimit    = 1_000_000;

  // Flavors of random request runs.
  localparam int unsigned SeqFill  = 0;
  localparam int unsigned SeqDrain = 1;
  localparam int unsigned SeqMixed = 2;

  logic clk_i;
  logic rst_ni;

  frqs_req_if req_ch ();
  frqs_rsp_if rsp_ch ();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          long_hold_req;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned dispatch_cnt;
  int unsigned empty_cnt;
  int unsigned full_cnt;
  int unsigned miss_cnt;

  fifo_ready_queue_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  frqs_dispatch_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_ch),
    .rsp_i          (rsp_ch),
    .fail_cnt_o     (fail_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt),
    .dispatch_cnt_o (dispatch_cnt),
    .empty_cnt_o    (empty_cnt),
    .full_cnt_o     (full_cnt),
    .miss_cnt_o     (miss_cnt)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_cnt, pending_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ids mostly come from a small pool so that terminates hit queued threads.
  function automatic logic [IdPortW-1:0] pick_id();
    if ($urandom_range(99) >= 70) return IdPortW'($urandom_range(255));
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      3:       return 8'hA5;
      4:       return 8'h01;
      5:       return 8'h80;
      6:       return 8'h3C;
      default: return 8'hC3;
    endcase
  endfunction

  function automatic action_e pick_action(input int unsigned kind);
    int unsigned roll;
    int unsigned enq_pct;
    int unsigned yld_pct;
    case (kind)
      SeqFill: begin
        enq_pct = 70;
        yld_pct = 12;
      end
      SeqDrain: begin
        enq_pct = 15;
        yld_pct = 45;
      end
      default: begin
        enq_pct = 40;
        yld_pct = 27;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < 3) return ACT_NONE;
    if (roll < 3 + enq_pct) return ACT_ENQUEUE;
    if (roll < 3 + enq_pct + yld_pct) return ACT_YIELD;
    return ACT_TERMINATE;
  endfunction

  // Offer one request after an optional random gap and wait until it is taken.
  task automatic send_request(input action_e act, input logic [IdPortW-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.thread_id <= tid;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Runs of requests that lean toward filling, draining or churning the queue.
  task automatic run_random(input int unsigned n_items);
    int unsigned done;
    int unsigned seq_len;
    int unsigned kind;
    done = 0;
    while (done < n_items) begin
      kind    = $urandom_range(SeqMixed);
      seq_len = $urandom_range(40, 4);
      for (int unsigned k = 0; k < seq_len && done < n_items; k++) begin
        send_request(pick_action(kind), pick_id());
        done++;
      end
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_ENQUEUE;
    req_ch.thread_id = '0;
    rsp_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    long_hold_req    = 1'b0;
    cycle_cnt        = 0;
    sent_cnt         = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: yield finds nothing, terminate misses, unused code is a no-op.
    send_request(ACT_YIELD, 8'h00);
    send_request(ACT_TERMINATE, 8'h00);
    send_request(ACT_NONE, 8'hFF);
    send_request(ACT_ENQUEUE, 8'h00);
    send_request(ACT_YIELD, 8'hFF);

    // Fill to capacity with a duplicate behind the head, then overflow once.
    send_request(ACT_ENQUEUE, 8'hA5);
    send_request(ACT_ENQUEUE, 8'hFF);
    send_request(ACT_ENQUEUE, 8'h5A);
    send_request(ACT_ENQUEUE, 8'hFF);
    for (int i = 0; i < QueueDepthDef - 4; i++) send_request(ACT_ENQUEUE, IdPortW'(8'h10 + i));
    send_request(ACT_ENQUEUE, 8'h33);

    // Remove the first duplicate, the tail, an absent id, then kill the running one.
    send_request(ACT_TERMINATE, 8'hFF);
    send_request(ACT_TERMINATE, IdPortW'(8'h10 + QueueDepthDef - 5));
    send_request(ACT_TERMINATE, 8'h33);
    send_request(ACT_TERMINATE, 8'h00);

    // Free-running traffic with a long result stall at the start.
    long_hold_req = 1'b1;
    run_random(ItemsPerPhase);

    send_idle_pct  = 61;
    recv_stall_pct = 0;
    run_random(ItemsPerPhase);

    send_idle_pct  = 0;
    recv_stall_pct = 61;
    run_random(ItemsPerPhase);

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    run_random(ItemsPerPhase);

    req_ch.valid <= 1'b0;
    wait (pending_cnt == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests across four pacing phases, one with a long result stall;",
             sent_cnt);
    $display("checked %0d results: %0d dispatches, %0d empty pops, %0d full drops, %0d misses, %0d mismatches.",
             checked_cnt, dispatch_cnt, empty_cnt, full_cnt, miss_cnt, fail_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
